// File: hdl/wavhp_pkg.sv
// types, codes and constants shared by the wav header parser and capture block
// no dependencies
package wavhp_pkg;

  // configuration register indexes
  localparam logic [1:0] CfgExpectedRate = 2'd0;
  localparam logic [1:0] CfgSkipBytes    = 2'd1;
  localparam logic [1:0] CfgWindowLength = 2'd2;

  localparam logic [31:0] ExpectedRateReset = 32'd8000;
  localparam logic [23:0] SkipBytesReset    = 24'd0;
  localparam logic [15:0] WindowLengthReset = 16'd512;

  // status codes
  localparam logic [2:0] StOk          = 3'd0;
  localparam logic [2:0] StRiffWave    = 3'd1;
  localparam logic [2:0] StFmtId       = 3'd2;
  localparam logic [2:0] StFmtLength   = 3'd3;
  localparam logic [2:0] StFormat      = 3'd4;
  localparam logic [2:0] StDataId      = 3'd5;
  localparam logic [2:0] StTruncSample = 3'd6;

  // chunk ids, first byte of the file in the top byte
  localparam logic [31:0] RiffId = 32'h52494646;
  localparam logic [31:0] WaveId = 32'h57415645;
  localparam logic [31:0] FmtId  = 32'h666d7420;
  localparam logic [31:0] DataId = 32'h64617461;

  localparam logic signed [7:0] MinInit = 8'sh7f;
  localparam logic signed [7:0] MaxInit = 8'sh80;

  typedef enum logic [7:0] {
    PhIdle     = 8'b0000_0001,
    PhMain     = 8'b0000_0010,
    PhFmtHdr   = 8'b0000_0100,
    PhFmtVal   = 8'b0000_1000,
    PhFmtExtra = 8'b0001_0000,
    PhDataHdr  = 8'b0010_0000,
    PhSkip     = 8'b0100_0000,
    PhWindow   = 8'b1000_0000
  } phase_e;

  typedef struct packed {
    logic       start_of_file;
    logic [7:0] file_byte;
    logic       end_of_file;
  } in_item_t;

  typedef struct packed {
    logic              kind;
    logic signed [7:0] sample;
    logic [2:0]        status;
    logic [7:0]        amplitude;
    logic              last;
  } out_item_t;

  // results produced by one byte, item0 first
  typedef struct packed {
    logic [1:0] n;
    out_item_t  item0;
    out_item_t  item1;
  } push_t;

  function automatic logic [7:0] id_byte(logic [31:0] id, logic [1:0] idx);
    logic [1:0] lane;
    lane = 2'd3 - idx;
    return id[{lane, 3'b000} +: 8];
  endfunction

  function automatic out_item_t make_status(logic [2:0] st, logic signed [7:0] mn,
                                            logic signed [7:0] mx);
    out_item_t  r;
    logic [8:0] diff;
    diff        = 9'({mx[7], mx}) - 9'({mn[7], mn});
    r           = '0;
    r.kind      = 1'b1;
    r.status    = st;
    r.last      = 1'b1;
    if (st == StOk && mx >= mn) begin
      r.amplitude = diff[7:0];
    end
    return r;
  endfunction

endpackage

// File: hdl/wav_header_parse_and_window_capture_core.sv
// top level: wav header parser with sample window capture
// depends on wavhp_pkg, wavhp_parser, wavhp_out_fifo
// path: a byte passes the input register, then the result queue
// throughput: one byte a cycle while the result queue has room; the final
// window byte gives two results, which leave the four-entry queue one by one
// reset: asynchronous; parse state, queue and config registers go to defaults
module wav_header_parse_and_window_capture_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [31:0]          cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  wavhp_pkg::in_item_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output wavhp_pkg::out_item_t out_data_o
);

  wavhp_pkg::push_t push;
  logic             space;

  wavhp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .space_i     (space),
    .push_o      (push)
  );

  wavhp_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// File: hdl/wavhp_parser.sv
// input register, configuration registers and the per-byte parse step
// depends on wavhp_pkg
module wavhp_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [31:0]         cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  wavhp_pkg::in_item_t in_data_i,
  input  logic                space_i,
  output wavhp_pkg::push_t    push_o
);

  logic [31:0] expected_rate_q;
  logic [23:0] skip_bytes_q;
  logic [15:0] window_length_q;

  logic                in_valid_q;
  wavhp_pkg::in_item_t in_item_q;
  logic                fire;

  wavhp_pkg::phase_e phase_q, phase_d;
  logic [23:0]       pos_q, pos_d;
  logic [31:0]       extra_q, extra_d;
  logic [31:0]       fa_q, fa_d;
  logic              idm_q, idm_d;
  logic              fmm_q, fmm_d;
  logic signed [7:0] min_q, min_d;
  logic signed [7:0] max_q, max_d;
  wavhp_pkg::push_t  push;

  assign fire       = in_valid_q && space_i;
  assign in_ready_o = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_rate_q <= wavhp_pkg::ExpectedRateReset;
      skip_bytes_q    <= wavhp_pkg::SkipBytesReset;
      window_length_q <= wavhp_pkg::WindowLengthReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        wavhp_pkg::CfgExpectedRate: expected_rate_q <= cfg_wdata_i;
        wavhp_pkg::CfgSkipBytes:    skip_bytes_q    <= cfg_wdata_i[23:0];
        wavhp_pkg::CfgWindowLength: window_length_q <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_item_q <= in_data_i;
    end
  end

  always_comb begin
    logic [7:0]        b;
    logic [23:0]       pinc;
    logic signed [7:0] s;
    phase_d = phase_q;
    pos_d   = pos_q;
    extra_d = extra_q;
    fa_d    = fa_q;
    idm_d   = idm_q;
    fmm_d   = fmm_q;
    min_d   = min_q;
    max_d   = max_q;
    push    = '0;
    b       = in_item_q.file_byte;
    s       = {~b[7], b[6:0]};
    pinc    = 24'd0;
    if (fire) begin
      if (in_item_q.start_of_file) begin
        phase_d = wavhp_pkg::PhMain;
        pos_d   = '0;
        extra_d = '0;
        fa_d    = '0;
        idm_d   = 1'b0;
        fmm_d   = 1'b0;
        min_d   = wavhp_pkg::MinInit;
        max_d   = wavhp_pkg::MaxInit;
      end
      pinc = pos_d + 24'd1;
      if (phase_d != wavhp_pkg::PhIdle && in_item_q.end_of_file) begin
        push.n = 2'd1;
        unique case (phase_d)
          wavhp_pkg::PhMain:
            push.item0 = wavhp_pkg::make_status(wavhp_pkg::StRiffWave, min_d, max_d);
          wavhp_pkg::PhFmtHdr:
            push.item0 = wavhp_pkg::make_status(wavhp_pkg::StFmtId, min_d, max_d);
          wavhp_pkg::PhFmtVal, wavhp_pkg::PhFmtExtra:
            push.item0 = wavhp_pkg::make_status(wavhp_pkg::StFmtLength, min_d, max_d);
          wavhp_pkg::PhDataHdr:
            push.item0 = wavhp_pkg::make_status(wavhp_pkg::StDataId, min_d, max_d);
          default:
            push.item0 = wavhp_pkg::make_status(wavhp_pkg::StTruncSample, min_d, max_d);
        endcase
        phase_d = wavhp_pkg::PhIdle;
      end else begin
        unique case (phase_d)
          wavhp_pkg::PhMain: begin
            if (pos_d < 24'd4 && b != wavhp_pkg::id_byte(wavhp_pkg::RiffId, pos_d[1:0])) begin
              idm_d = 1'b1;
            end
            if (pos_d >= 24'd8 && pos_d < 24'd12 &&
                b != wavhp_pkg::id_byte(wavhp_pkg::WaveId, pos_d[1:0])) begin
              idm_d = 1'b1;
            end
            pos_d = pinc;
            if (pinc >= 24'd12) begin
              if (idm_d) begin
                push.n     = 2'd1;
                push.item0 = wavhp_pkg::make_status(wavhp_pkg::StRiffWave, min_d, max_d);
                phase_d    = wavhp_pkg::PhIdle;
              end else begin
                phase_d = wavhp_pkg::PhFmtHdr;
                pos_d   = '0;
                fa_d    = '0;
              end
            end
          end
          wavhp_pkg::PhFmtHdr: begin
            if (pos_d < 24'd4) begin
              if (b != wavhp_pkg::id_byte(wavhp_pkg::FmtId, pos_d[1:0])) begin
                idm_d = 1'b1;
              end
            end else if (pos_d < 24'd8) begin
              fa_d[{pos_d[1:0], 3'b000} +: 8] = fa_d[{pos_d[1:0], 3'b000} +: 8] | b;
            end
            pos_d = pinc;
            if (pinc >= 24'd8) begin
              if (idm_d) begin
                push.n     = 2'd1;
                push.item0 = wavhp_pkg::make_status(wavhp_pkg::StFmtId, min_d, max_d);
                phase_d    = wavhp_pkg::PhIdle;
              end else if (fa_d < 32'd16) begin
                push.n     = 2'd1;
                push.item0 = wavhp_pkg::make_status(wavhp_pkg::StFmtLength, min_d, max_d);
                phase_d    = wavhp_pkg::PhIdle;
              end else begin
                extra_d = fa_d - 32'd16;
                phase_d = wavhp_pkg::PhFmtVal;
                pos_d   = '0;
                fmm_d   = 1'b0;
              end
            end
          end
          wavhp_pkg::PhFmtVal, wavhp_pkg::PhFmtExtra: begin
            logic check;
            check = 1'b0;
            if (phase_d == wavhp_pkg::PhFmtVal) begin
              // audio format and channel count are both little-endian one
              if ((pos_d == 24'd0 || pos_d == 24'd2) && b != 8'd1) fmm_d = 1'b1;
              if ((pos_d == 24'd1 || pos_d == 24'd3 || pos_d == 24'd15) && b != 8'd0) begin
                fmm_d = 1'b1;
              end
              if (pos_d >= 24'd4 && pos_d < 24'd8 &&
                  b != expected_rate_q[{pos_d[1:0], 3'b000} +: 8]) begin
                fmm_d = 1'b1;
              end
              if (pos_d == 24'd14 && b != 8'd8) fmm_d = 1'b1;
              pos_d = pinc;
              if (pinc >= 24'd16) begin
                if (extra_d == '0) check = 1'b1;
                else phase_d = wavhp_pkg::PhFmtExtra;
              end
            end else begin
              if (extra_d != '0) extra_d = extra_d - 32'd1;
              if (extra_d == '0) check = 1'b1;
            end
            if (check) begin
              if (fmm_d) begin
                push.n     = 2'd1;
                push.item0 = wavhp_pkg::make_status(wavhp_pkg::StFormat, min_d, max_d);
                phase_d    = wavhp_pkg::PhIdle;
              end else begin
                phase_d = wavhp_pkg::PhDataHdr;
                pos_d   = '0;
                idm_d   = 1'b0;
              end
            end
          end
          wavhp_pkg::PhDataHdr, wavhp_pkg::PhSkip: begin
            logic to_window;
            to_window = 1'b0;
            pos_d     = pinc;
            if (phase_d == wavhp_pkg::PhDataHdr) begin
              if (pinc <= 24'd4 && b != wavhp_pkg::id_byte(wavhp_pkg::DataId, pinc[1:0] - 2'd1)) begin
                idm_d = 1'b1;
              end
              if (pinc >= 24'd8) begin
                if (idm_d) begin
                  push.n     = 2'd1;
                  push.item0 = wavhp_pkg::make_status(wavhp_pkg::StDataId, min_d, max_d);
                  phase_d    = wavhp_pkg::PhIdle;
                end else begin
                  phase_d = wavhp_pkg::PhSkip;
                  pos_d   = '0;
                  if (skip_bytes_q == '0) to_window = 1'b1;
                end
              end
            end else if (pinc >= skip_bytes_q) begin
              to_window = 1'b1;
            end
            if (to_window) begin
              phase_d = wavhp_pkg::PhWindow;
              pos_d   = '0;
              min_d   = wavhp_pkg::MinInit;
              max_d   = wavhp_pkg::MaxInit;
              if (window_length_q == '0) begin
                push.n     = 2'd1;
                push.item0 = wavhp_pkg::make_status(wavhp_pkg::StOk, min_d, max_d);
                phase_d    = wavhp_pkg::PhIdle;
              end
            end
          end
          wavhp_pkg::PhWindow: begin
            push.n            = 2'd1;
            push.item0        = '0;
            push.item0.sample = s;
            if (s < min_d) min_d = s;
            if (s > max_d) max_d = s;
            pos_d = pinc;
            if (pinc >= {8'd0, window_length_q}) begin
              push.n     = 2'd2;
              push.item1 = wavhp_pkg::make_status(wavhp_pkg::StOk, min_d, max_d);
              phase_d    = wavhp_pkg::PhIdle;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= wavhp_pkg::PhIdle;
      pos_q   <= '0;
      extra_q <= '0;
      fa_q    <= '0;
      idm_q   <= 1'b0;
      fmm_q   <= 1'b0;
      min_q   <= wavhp_pkg::MinInit;
      max_q   <= wavhp_pkg::MaxInit;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      extra_q <= extra_d;
      fa_q    <= fa_d;
      idm_q   <= idm_d;
      fmm_q   <= fmm_d;
      min_q   <= min_d;
      max_q   <= max_d;
    end
  end

  assign push_o = push;

endmodule

// File: hdl/wavhp_out_fifo.sv
// four-entry result queue taking up to two results a cycle while it has room, one out a cycle while the output is ready
// depends on wavhp_pkg
module wavhp_out_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  wavhp_pkg::push_t     push_i,
  output logic                 space_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output wavhp_pkg::out_item_t out_data_o
);

  wavhp_pkg::out_item_t mem_q [4];
  logic [1:0] wr_ptr_q, rd_ptr_q;
  logic [2:0] count_q;
  logic       pop;

  assign out_valid_o = count_q != 3'd0;
  assign out_data_o  = mem_q[rd_ptr_q];
  assign pop         = out_valid_o && out_ready_i;
  // room for the worst case of two results from the next byte
  assign space_o     = count_q <= 3'd2;

  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) mem_q[wr_ptr_q] <= push_i.item0;
    if (push_i.n == 2'd2) mem_q[wr_ptr_q + 2'd1] <= push_i.item1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + push_i.n;
      if (pop) rd_ptr_q <= rd_ptr_q + 2'd1;
      count_q <= count_q + {1'b0, push_i.n} - {2'b00, pop};
    end
  end

endmodule
